@@ rtl/bitmap_page_frame_allocator_core_macros.svh @@
// Assertion macros shared by the checker of the page-frame allocator core.
// The clock is i_clk and the synchronous active-low reset is i_rst_n.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_MACROS_SVH

// Property that is checked only while the block is out of reset.
`define BPFA_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property that is checked on every clock edge, reset cycles included.
`define BPFA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/bpfa_pkg.sv @@
// Shared types and constants of the bitmap page-frame allocator.
// Used by every module of the block but bpfa_ram; depends on nothing.
`timescale 1ns / 1ps

package bpfa_pkg;

    // Field widths of the stream words and the configuration port.
    localparam int PAGE_W      = 18;
    localparam int RUN_W       = 19;
    localparam int CFG_W       = 19;
    localparam int ACT_W       = 2;
    localparam int IDX_W       = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Page positions inside the block: a range end stays below 2^18 + 2^19.
    localparam int POS_W = 20;

    // Default geometry of the bitmap.
    localparam int NUM_PAGES_DEF = 262144;
    localparam int WORD_BITS_DEF = 64;

    // Register indexes and their reset values (floor is one megabyte of 4 KiB pages).
    localparam logic [IDX_W-1:0] REG_PAGE_COUNT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_ALLOC_FLOOR = 2'd1;
    localparam logic [CFG_W-1:0] PAGE_COUNT_RESET = 19'd262144;
    localparam logic [CFG_W-1:0] FLOOR_RESET      = CFG_W'(32'h0010_0000 / 4096);

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_RESERVE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_WALK,
        ST_DRAIN
    } t_state;

    // Request from the word walker to the free-count pipeline.
    typedef struct packed {
        logic valid;
        logic inc;
    } t_cnt_req;

endpackage

@@ rtl/bpfa_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bpfa_div.sv @@
// Word/bit splitter: turns a page number into bitmap word address and bit offset.
// WORD_BITS is a power of two, so the split is a shift and a mask; uses bpfa_pkg.
`timescale 1ns / 1ps

module bpfa_div #(
    parameter int WORD_BITS = bpfa_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_start,
    input  logic [bpfa_pkg::POS_W-1:0]      i_dividend,
    output logic [bpfa_pkg::POS_W-1:0]      o_quo,
    output logic [$clog2(WORD_BITS)-1:0]    o_rem
);

    localparam int POS_W = bpfa_pkg::POS_W;
    localparam int BIW   = $clog2(WORD_BITS);

    logic [POS_W-1:0] r_quo;
    logic [BIW-1:0]   r_rem;

    // Capture word address and bit offset when a request is accepted.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend >> BIW;
            r_rem <= i_dividend[BIW-1:0];
        end
    end

    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

@@ rtl/bpfa_count.sv @@
// Free-count pipeline: counts the bits that flipped in one bitmap word and
// updates the free total. Three stages; uses bpfa_pkg.
`timescale 1ns / 1ps

module bpfa_count #(
    parameter int WORD_BITS = bpfa_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpfa_pkg::t_cnt_req            i_req,
    input  logic [WORD_BITS-1:0]          i_mask,
    output logic                          o_busy,
    output logic [bpfa_pkg::CFG_W-1:0]    o_total
);

    localparam int CFG_W = bpfa_pkg::CFG_W;
    localparam int NGRP  = (WORD_BITS + 7) / 8;
    localparam int PADW  = NGRP * 8;
    localparam int CW    = $clog2(WORD_BITS + 1);

    logic             r_s1_v;
    logic             r_s1_inc;
    logic [PADW-1:0]  r_s1_mask;
    logic             r_s2_v;
    logic             r_s2_inc;
    logic [3:0]       r_s2_grp [NGRP];
    logic [3:0]       w_grp [NGRP];
    logic [CW-1:0]    w_sum;
    logic [CFG_W-1:0] r_total;

    // Stage 1: capture the flip mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_inc  <= i_req.inc;
        r_s1_mask <= PADW'(i_mask);
    end

    // Stage 2: population count of each byte of the mask.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp[g] = '0;
            for (int b = 0; b < 8; b++) begin
                w_grp[g] = w_grp[g] + 4'(r_s1_mask[g * 8 + b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_inc <= r_s1_inc;
        r_s2_grp <= w_grp;
    end

    // Stage 3: add the byte counts and apply them to the free total.
    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_sum = w_sum + CW'(r_s2_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (r_s2_v) begin
            if (r_s2_inc) begin
                r_total <= r_total + CFG_W'(w_sum);
            end else begin
                r_total <= r_total - CFG_W'(w_sum);
            end
        end
    end

    assign o_busy  = r_s1_v | r_s2_v;
    assign o_total = r_total;

endmodule

@@ rtl/bitmap_page_frame_allocator_core.sv @@
// Top level of the bitmap page-frame allocator: sequencer, word walker and
// output register. Depends on bpfa_pkg, bpfa_ram, bpfa_div and bpfa_count.
//
// Usage:
// The slave stream takes one request word: tuser holds the action (allocate,
// free page, release range, reserve range), tdata the page and run length.
// The master stream returns one word per request: tuser is the success flag,
// tdata holds the allocated page and the free count after the action.
// page_count and alloc_floor are written through the configuration port
// while no request is in flight. WORD_BITS must be a power of two.
// A request passes through these steps after acceptance: the start page is
// split into word and bit, the first bitmap word is read, the walk visits the
// words one per cycle through the one-port-read RAM, and the free-count
// pipeline drains. A request whose page window is empty skips the read and
// the walk. A range of R pages visits about R / WORD_BITS words; an allocate
// visits the words from the floor up to the first free page. Requests are
// handled one at a time; the next one is taken in the cycle its predecessor's
// result appears.
// After reset every page is busy and the free count is zero; a clearing pass
// writes ones into every bitmap word (NUM_PAGES / WORD_BITS rounded up, 4096 by
// default), and s_axis_tready stays low until it ends.
// A finished result waits in the output register while the receiver stalls;
// the next request is accepted meanwhile but its result waits for the slot.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_core #(
    parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF,
    parameter int WORD_BITS = bpfa_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [bpfa_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [bpfa_pkg::CFG_W-1:0]          i_cfg_data,
    // Request stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bpfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // page[17:0], run_length[36:18]
    input  logic [bpfa_pkg::ACT_W-1:0]          s_axis_tuser,  // action[1:0]
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bpfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // result_page[17:0], free_count[36:18]
    output logic                                m_axis_tuser   // ok[0]
);

    localparam int POS_W  = bpfa_pkg::POS_W;
    localparam int PAGE_W = bpfa_pkg::PAGE_W;
    localparam int RUN_W  = bpfa_pkg::RUN_W;
    localparam int CFG_W  = bpfa_pkg::CFG_W;
    localparam int DEPTH  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIW    = $clog2(WORD_BITS);
    localparam int CAP    = (NUM_PAGES < 524288) ? NUM_PAGES : 524288;
    localparam logic [POS_W-1:0] LIMIT_CAP = POS_W'(CAP);
    localparam logic [POS_W-1:0] WB_POS    = POS_W'(WORD_BITS);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam int PAD_W = bpfa_pkg::OUT_TDATA_W - PAGE_W - CFG_W;

    bpfa_pkg::t_state  r_state, n_state;
    bpfa_pkg::t_action r_action, n_action;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [CFG_W-1:0]  r_page_count;
    logic [CFG_W-1:0]  r_alloc_floor;
    logic [POS_W-1:0]  r_start, n_start;
    logic [POS_W-1:0]  r_end, n_end;
    logic [POS_W-1:0]  r_base, n_base;
    logic [BIW-1:0]    r_lo_bit, n_lo_bit;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_ok, n_ok;
    logic [POS_W-1:0]  r_got, n_got;
    logic              r_out_valid, n_out_valid;
    logic              r_out_ok, n_out_ok;
    logic [PAGE_W-1:0] r_out_page, n_out_page;
    logic [CFG_W-1:0]  r_out_free, n_out_free;

    // Request decode.
    bpfa_pkg::t_action w_in_act;
    logic [POS_W-1:0]  w_limit;
    logic [POS_W-1:0]  w_in_page;
    logic [POS_W-1:0]  w_in_run;
    logic [POS_W-1:0]  w_in_start;
    logic [POS_W-1:0]  w_in_raw_end;
    logic [POS_W-1:0]  w_in_end;
    logic              w_accept;

    // Word walker.
    logic [WORD_BITS-1:0] w_rd_word;
    logic [WORD_BITS-1:0] w_lo_mask;
    logic [WORD_BITS-1:0] w_hi_mask;
    logic [WORD_BITS-1:0] w_avail;
    logic [WORD_BITS-1:0] w_flip;
    logic [WORD_BITS-1:0] w_new_word;
    logic [POS_W-1:0]     w_span;
    logic [POS_W-1:0]     w_next_base;
    logic [BIW-1:0]       w_low_idx;
    logic                 w_low_any;
    logic                 w_clears;
    logic                 w_is_alloc;
    logic                 w_more;

    // Memory ports.
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;

    // Word/bit split and count pipeline.
    logic [POS_W-1:0]     w_div_quo;
    logic [BIW-1:0]       w_div_rem;
    bpfa_pkg::t_cnt_req   w_cnt_req;
    logic                 w_cnt_busy;
    logic [CFG_W-1:0]     w_free_total;

    assign s_axis_tready = (r_state == bpfa_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Managed limit and the page window of an incoming request.
    always_comb begin
        w_in_act     = bpfa_pkg::t_action'(s_axis_tuser);
        w_in_page    = POS_W'(s_axis_tdata[PAGE_W-1:0]);
        w_in_run     = POS_W'(s_axis_tdata[PAGE_W+RUN_W-1:PAGE_W]);
        w_limit      = (POS_W'(r_page_count) < LIMIT_CAP) ? POS_W'(r_page_count) : LIMIT_CAP;
        w_in_start   = w_in_page;
        w_in_raw_end = w_in_page + w_in_run;
        case (w_in_act) inside
            bpfa_pkg::ACT_ALLOC: begin
                w_in_start   = POS_W'(r_alloc_floor);
                w_in_raw_end = w_limit;
            end
            bpfa_pkg::ACT_FREE: begin
                w_in_raw_end = w_in_page + POS_W'(1);
            end
            bpfa_pkg::ACT_RELEASE, bpfa_pkg::ACT_RESERVE: begin
                w_in_raw_end = w_in_page + w_in_run;
            end
            default: begin
                w_in_raw_end = w_limit;
            end
        endcase
        w_in_end = (w_in_raw_end < w_limit) ? w_in_raw_end : w_limit;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count  <= bpfa_pkg::PAGE_COUNT_RESET;
            r_alloc_floor <= bpfa_pkg::FLOOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpfa_pkg::REG_PAGE_COUNT:  r_page_count  <= i_cfg_data;
                bpfa_pkg::REG_ALLOC_FLOOR: r_alloc_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Splits the start page into word address and bit offset.
    bpfa_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_start    (w_accept),
        .i_dividend (w_in_start),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    // Occupancy bitmap, one word per entry, 1 = busy.
    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_word)
    );

    // Per-word modify: select the bits in the window that would change.
    always_comb begin
        w_is_alloc  = (r_action == bpfa_pkg::ACT_ALLOC);
        w_clears    = (r_action == bpfa_pkg::ACT_FREE) || (r_action == bpfa_pkg::ACT_RELEASE);
        w_span      = r_end - r_base;
        w_next_base = r_base + WB_POS;
        for (int j = 0; j < WORD_BITS; j++) begin
            w_lo_mask[j] = (BIW'(j) >= r_lo_bit);
            w_hi_mask[j] = (POS_W'(j) < w_span);
        end
        w_avail = w_lo_mask & w_hi_mask & (w_clears ? w_rd_word : ~w_rd_word);
        w_low_idx = '0;
        w_low_any = 1'b0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_avail[j]) begin
                w_low_idx = BIW'(j);
                w_low_any = 1'b1;
            end
        end
        if (w_is_alloc) begin
            w_flip = w_low_any ? (WORD_BITS'(1) << w_low_idx) : '0;
        end else begin
            w_flip = w_avail;
        end
        w_new_word = w_clears ? (w_rd_word & ~w_flip) : (w_rd_word | w_flip);
        w_more     = !(w_is_alloc && w_low_any) && (w_next_base < r_end);
    end

    // Memory port control: clearing pass, first read, walk with read-ahead.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_new_word;
        w_re    = 1'b0;
        w_raddr = r_addr;
        if (r_state == bpfa_pkg::ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '1;
        end else if (r_state == bpfa_pkg::ST_READ) begin
            w_re = 1'b1;
        end else if (r_state == bpfa_pkg::ST_WALK) begin
            w_we    = 1'b1;
            w_re    = w_more;
            w_raddr = r_addr + AW'(1);
        end
    end

    assign w_cnt_req.valid = (r_state == bpfa_pkg::ST_WALK);
    assign w_cnt_req.inc   = w_clears;

    // Counts the flipped bits and keeps the free total.
    bpfa_count #(
        .WORD_BITS (WORD_BITS)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cnt_req),
        .i_mask  (w_flip),
        .o_busy  (w_cnt_busy),
        .o_total (w_free_total)
    );

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_clr_addr  = r_clr_addr;
        n_start     = r_start;
        n_end       = r_end;
        n_base      = r_base;
        n_lo_bit    = r_lo_bit;
        n_addr      = r_addr;
        n_ok        = r_ok;
        n_got       = r_got;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_ok    = r_out_ok;
        n_out_page  = r_out_page;
        n_out_free  = r_out_free;
        unique case (r_state)
            bpfa_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = bpfa_pkg::ST_IDLE;
                end
            end
            bpfa_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_action = w_in_act;
                    n_start  = w_in_start;
                    n_end    = w_in_end;
                    n_ok     = (w_in_act == bpfa_pkg::ACT_RELEASE) ||
                               (w_in_act == bpfa_pkg::ACT_RESERVE);
                    n_got    = '0;
                    n_state  = bpfa_pkg::ST_DIV;
                end
            end
            bpfa_pkg::ST_DIV: begin
                n_base   = r_start - POS_W'(w_div_rem);
                n_lo_bit = w_div_rem;
                n_addr   = AW'(w_div_quo);
                n_state  = (r_start >= r_end) ? bpfa_pkg::ST_DRAIN : bpfa_pkg::ST_READ;
            end
            bpfa_pkg::ST_READ: begin
                n_state = bpfa_pkg::ST_WALK;
            end
            bpfa_pkg::ST_WALK: begin
                if (w_is_alloc && w_low_any) begin
                    n_ok  = 1'b1;
                    n_got = r_base + POS_W'(w_low_idx);
                end else if (r_action == bpfa_pkg::ACT_FREE) begin
                    n_ok = |w_flip;
                end
                if (w_more) begin
                    n_base   = w_next_base;
                    n_lo_bit = '0;
                    n_addr   = r_addr + AW'(1);
                end else begin
                    n_state = bpfa_pkg::ST_DRAIN;
                end
            end
            bpfa_pkg::ST_DRAIN: begin
                if (!w_cnt_busy && (!r_out_valid || m_axis_tready)) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_page  = PAGE_W'(r_got);
                    n_out_free  = w_free_total;
                    n_state     = bpfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bpfa_pkg::ST_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpfa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_start    <= n_start;
        r_end      <= n_end;
        r_base     <= n_base;
        r_lo_bit   <= n_lo_bit;
        r_addr     <= n_addr;
        r_ok       <= n_ok;
        r_got      <= n_got;
        r_out_ok   <= n_out_ok;
        r_out_page <= n_out_page;
        r_out_free <= n_out_free;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_free, r_out_page};

endmodule

@@ rtl/bpfa_checker.sv @@
// Port-level checker for the page-frame allocator core, bound to the top level.
// Depends on bpfa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bitmap_page_frame_allocator_core_macros.svh"

module bpfa_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bpfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tuser
);

    // The clearing pass after reset keeps the request side closed.
    `BPFA_ASSERT_ALWAYS(a_clear_blocks, !i_rst_n |=> !s_axis_tready, "request taken during clearing pass")

    // Requests are handled one at a time.
    `BPFA_ASSERT_RUN(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second request taken while busy")

    // A stalled result word holds.
    `BPFA_ASSERT_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")

    // A failed action never reports an allocated page.
    `BPFA_ASSERT_RUN(a_fail_page_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[17:0] == 18'd0, "failed action reports a page")

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (.*);
